>>> rtl/multi_reader_midi_rx_ring_defines.svh
// Assertion macros used by the receive ring checker.
`ifndef MULTI_READER_MIDI_RX_RING_DEFINES_SVH
`define MULTI_READER_MIDI_RX_RING_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define MRMRX_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mrmrx: check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define MRMRX_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mrmrx: check failed");

`endif

>>> rtl/mrmrx_pkg.sv
// Types and constants of the multi-reader MIDI receive ring.
package mrmrx_pkg;

   // RING_DEPTH must be a power of two: counts wrap at twice the depth.
   localparam int RING_DEPTH  = 1024;
   localparam int NUM_READERS = 4;
   localparam int ADDR_W      = $clog2(RING_DEPTH);
   localparam int CNT_W       = ADDR_W + 1;
   localparam int RD_IDX_W    = (NUM_READERS > 1) ? $clog2(NUM_READERS) : 1;

   localparam logic [7:0] ACK_BYTE = 8'hFE;

   // Bit positions of the result flags in rsp_tuser.
   localparam int FLAG_VALID  = 0;
   localparam int FLAG_ACK    = 1;
   localparam int FLAG_STORED = 2;

   typedef enum logic [2:0] {
      FUNC_RX    = 3'd0,
      FUNC_READ  = 3'd1,
      FUNC_OPEN  = 3'd2,
      FUNC_CLOSE = 3'd3,
      FUNC_ARM   = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } state_type;

endpackage

>>> rtl/multi_reader_midi_rx_ring.sv
// Receive ring of a MIDI interface with several independent readers.
//
// Request channel (req_): one word per operation. tuser carries func and
// reader, tdata the received byte. Response channel (rsp_): exactly one
// word per request; tdata is the byte read, tuser the flags read_valid,
// ack_seen and stored.
// Response path: a read that returns a byte answers through the ring
// memory read register and then the output register; every other
// operation answers in the next cycle.
// Throughput: one word per cycle while the receiver takes responses; a
// read that returns a byte holds the request side while the single ring
// read port delivers its data to the output register.
// The output register frees up in the cycle the response is taken, so a
// new request can go in while the previous response drains. While the
// receiver stalls with a response pending, req_tready stays low.
// Reset closes all readers, zeroes the write count and read positions and
// disarms the acknowledge wait. The ring memory itself is not cleared,
// so the block is ready as soon as reset is released.
module multi_reader_midi_rx_ring (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // rx_byte[7:0]
   input  logic [4:0] req_tuser,   // func[2:0], reader[4:3]
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // read_data[7:0]
   output logic [2:0] rsp_tuser    // read_valid[0], ack_seen[1], stored[2]
);
   import mrmrx_pkg::*;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     wcount_ff, wcount_in;
   logic [CNT_W-1:0]     pos_ff [NUM_READERS];
   logic [CNT_W-1:0]     pos_in [NUM_READERS];
   logic [NUM_READERS-1:0] open_ff, open_in;
   logic                 ack_wait_ff, ack_wait_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [2:0]           rsp_flags_ff, rsp_flags_in;
   logic [7:0]           rsp_data_ff, rsp_data_in;

   logic [7:0]           ring_mem [RING_DEPTH];
   logic [7:0]           mem_rd_ff;
   logic                 mem_we, mem_re;
   logic [ADDR_W-1:0]    mem_waddr, mem_raddr;

   logic                 accept, any_open, rd_ok;
   func_type             func;
   logic [1:0]           req_reader;
   logic [RD_IDX_W-1:0]  rd_idx;
   logic [CNT_W-1:0]     wcount_inc, trim_pos;
   logic [CNT_W-1:0]     backlog [NUM_READERS];

   assign func       = func_type'(req_tuser[2:0]);
   assign req_reader = req_tuser[4:3];
   assign rd_idx     = req_reader[RD_IDX_W-1:0];
   assign rd_ok      = 32'(req_reader) < NUM_READERS;
   assign any_open   = |open_ff;
   assign wcount_inc = wcount_ff + CNT_W'(1);
   // oldest position kept after an overrun: new count minus depth plus one
   assign trim_pos   = wcount_inc + CNT_W'(RING_DEPTH + 1);

   assign req_tready = !reset && (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign mem_waddr  = wcount_ff[ADDR_W-1:0];
   assign mem_raddr  = pos_ff[rd_idx][ADDR_W-1:0];

   always_comb begin
      for (int i = 0; i < NUM_READERS; i++) begin
         backlog[i] = wcount_inc - pos_ff[i];
      end
   end

   always_comb begin
      state_in     = state_ff;
      wcount_in    = wcount_ff;
      pos_in       = pos_ff;
      open_in      = open_ff;
      ack_wait_in  = ack_wait_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_flags_in = rsp_flags_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;

      if (state_ff == ST_READ) begin
         // ring data is out now; the output register is known to be free
         rsp_valid_in             = 1'b1;
         rsp_data_in              = mem_rd_ff;
         rsp_flags_in             = '0;
         rsp_flags_in[FLAG_VALID] = 1'b1;
         state_in                 = ST_IDLE;
      end else if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_flags_in = '0;
         unique case (func)
            FUNC_RX: begin
               if (any_open) begin
                  if (req_tdata == ACK_BYTE) begin
                     if (ack_wait_ff) begin
                        ack_wait_in            = 1'b0;
                        rsp_flags_in[FLAG_ACK] = 1'b1;
                     end
                  end else begin
                     mem_we                    = 1'b1;
                     wcount_in                 = wcount_inc;
                     rsp_flags_in[FLAG_STORED] = 1'b1;
                     // drop the oldest byte of every open reader a full ring behind
                     for (int i = 0; i < NUM_READERS; i++) begin
                        if (open_ff[i] && backlog[i][ADDR_W]) begin
                           pos_in[i] = trim_pos;
                        end
                     end
                  end
               end
            end
            FUNC_READ: begin
               if (rd_ok && open_ff[rd_idx] && (pos_ff[rd_idx] != wcount_ff)) begin
                  mem_re         = 1'b1;
                  pos_in[rd_idx] = pos_ff[rd_idx] + CNT_W'(1);
                  rsp_valid_in   = 1'b0;
                  state_in       = ST_READ;
               end
            end
            FUNC_OPEN: begin
               if (rd_ok) begin
                  if (!any_open) begin
                     wcount_in      = '0;
                     pos_in[rd_idx] = '0;
                  end else begin
                     pos_in[rd_idx] = wcount_ff;
                  end
                  open_in[rd_idx] = 1'b1;
               end
            end
            FUNC_CLOSE: begin
               if (rd_ok) begin
                  open_in[rd_idx] = 1'b0;
               end
            end
            FUNC_ARM: begin
               ack_wait_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wcount_ff    <= '0;
         open_ff      <= '0;
         ack_wait_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_READERS; i++) begin
            pos_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         wcount_ff    <= wcount_in;
         open_ff      <= open_in;
         ack_wait_ff  <= ack_wait_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_flags_ff <= rsp_flags_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_waddr] <= req_tdata;
      end
      if (mem_re) begin
         mem_rd_ff <= ring_mem[mem_raddr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_flags_ff;

endmodule

>>> rtl/mrmrx_checker.sv
// Port-level checks of the receive ring, bound to the top level.
`include "multi_reader_midi_rx_ring_defines.svh"

module mrmrx_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [7:0] req_tdata,   // rx_byte[7:0]
   input logic [4:0] req_tuser,   // func[2:0], reader[4:3]
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,   // read_data[7:0]
   input logic [2:0] rsp_tuser    // read_valid[0], ack_seen[1], stored[2]
);
   import mrmrx_pkg::*;

   logic close_taken;

   assign close_taken = req_tvalid && req_tready && (req_tuser[2:0] == FUNC_CLOSE)
                        && (req_tdata == req_tdata);

   // hold a stalled response
   `MRMRX_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   // one operation raises at most one flag
   `MRMRX_ASSERT_NOW(a_one_flag, rsp_tvalid, $countones(rsp_tuser) <= 1)
   // data is zero unless a byte was returned
   `MRMRX_ASSERT_NOW(a_data_zero, rsp_tvalid && !rsp_tuser[FLAG_VALID], rsp_tdata == 8'd0)
   // a close answers in the next cycle with all flags low
   `MRMRX_ASSERT_NEXT(a_close_rsp, close_taken, rsp_tvalid && (rsp_tuser == 3'd0))
   // no response pending right after reset
   `MRMRX_ASSERT_NOW(a_reset_empty, $past(reset), !rsp_tvalid)

endmodule

bind multi_reader_midi_rx_ring mrmrx_checker u_mrmrx_checker (.*);
